// File: hw/rtl/aap_pkg.sv
// ----------------------------------------------------------------------------
// aap_pkg
// Shared constants and the arctangent table for the axis-angle rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package aap_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int AXIS_W           = 16;
	localparam int ANGLE_W          = 16;
	// CORDIC datapath width: Q.30 values with headroom for gain and sign.
	localparam int CD_W             = 34;
	localparam logic signed [CD_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CD_W-1:0] ONE_Q30  = 34'sd1073741824;

	function automatic logic [31:0] atan_entry(input int unsigned idx);
		logic [31:0] r;
		unique case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aap_cordic.sv
// ----------------------------------------------------------------------------
// aap_cordic
// Unrolled rotation-mode CORDIC, one stage per step, with half-turn fold.
// ----------------------------------------------------------------------------
`default_nettype none

module aap_cordic
	import aap_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire        [ANGLE_W-1:0]     angle,
	output logic                         out_valid,
	output logic signed [CD_W-1:0]       cos_val,
	output logic signed [CD_W-1:0]       sin_val
);

	logic                   v_s    [0:STEPS];
	logic                   fold_s [0:STEPS];
	logic signed [CD_W-1:0] x_s    [0:STEPS];
	logic signed [CD_W-1:0] y_s    [0:STEPS];
	logic signed [CD_W-1:0] z_s    [0:STEPS];

	logic        fold_in;
	logic [31:0] a_in;

	// Fold angles beyond a quarter turn by a half turn.
	assign fold_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
	assign a_in    = {angle[ANGLE_W-1] ^ fold_in, angle[ANGLE_W-2:0], 16'h0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		fold_s[0] <= fold_in;
		x_s[0]    <= GAIN_Q30;
		y_s[0]    <= '0;
		z_s[0]    <= CD_W'($signed(a_in));
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [CD_W-1:0] ATAN = CD_W'(atan_entry(i));
		logic signed [CD_W-1:0] dx, dy;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			fold_s[i+1] <= fold_s[i];
			if (!z_s[i][CD_W-1]) begin
				x_s[i+1] <= x_s[i] - dy;
				y_s[i+1] <= y_s[i] + dx;
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + dy;
				y_s[i+1] <= y_s[i] - dx;
				z_s[i+1] <= z_s[i] + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[STEPS];
		end
	end

	// Undo the fold by negating both results.
	always_ff @(posedge clk) begin
		cos_val <= fold_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		sin_val <= fold_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	end

endmodule

`default_nettype wire

// File: hw/rtl/axis_angle_point_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotation
// Rotates a Q16.16 point about a Q1.14 unit axis by a binary angle.
// ----------------------------------------------------------------------------
// The block is fully pipelined and never stalls: busy is always low, so a
// beat may be started in every cycle, and each beat returns exactly one
// result, marked by done for one cycle. The pipeline is the unrolled CORDIC
// (one stage per step plus entry and exit registers) followed by seven
// stages of matrix build and the matrix-vector product. The receiver cannot
// hold results off; it must take each done beat when it appears. Results
// saturate and raise clipped.
`default_nettype none

module axis_angle_point_rotation
	import aap_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  signed [COORD_WIDTH-1:0] point_x,
	input  wire  signed [COORD_WIDTH-1:0] point_y,
	input  wire  signed [COORD_WIDTH-1:0] point_z,
	input  wire  signed [AXIS_W-1:0]      axis_x,
	input  wire  signed [AXIS_W-1:0]      axis_y,
	input  wire  signed [AXIS_W-1:0]      axis_z,
	input  wire  signed [ANGLE_W-1:0]     turn_angle,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z,
	output logic                          clipped
);

	localparam int CW     = COORD_WIDTH;
	localparam int LAT    = CORDIC_STEPS + 2;
	localparam int UV_W   = 2 * AXIS_W;
	localparam int OP_W   = CD_W + UV_W;
	localparam int CP_W   = CD_W + AXIS_W;
	localparam int MAT_W  = 36;
	localparam int SPLIT  = CW / 2;
	localparam int PH_W   = CW - SPLIT;
	localparam int HP_W   = MAT_W + PH_W;
	localparam int LP_W   = MAT_W + SPLIT + 1;
	localparam int HS_W   = HP_W + 2;
	localparam int LS_W   = LP_W + 2;
	localparam int TOT_W  = HS_W + SPLIT + 2;
	localparam int RES_W  = TOT_W - 30;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---------------- sine / cosine ----------------
	logic                   cs_valid;
	logic signed [CD_W-1:0] cos_v, sin_v;

	aap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (turn_angle),
		.out_valid (cs_valid),
		.cos_val   (cos_v),
		.sin_val   (sin_v)
	);

	// ---------------- delay line: point and axis ride beside the CORDIC ----
	logic signed [CW-1:0]     pt_q [0:LAT-1][0:2];
	logic signed [AXIS_W-1:0] ax_q [0:LAT-1][0:2];

	always_ff @(posedge clk) begin
		pt_q[0][0] <= point_x;
		pt_q[0][1] <= point_y;
		pt_q[0][2] <= point_z;
		ax_q[0][0] <= axis_x;
		ax_q[0][1] <= axis_y;
		ax_q[0][2] <= axis_z;
		for (int d = 1; d < LAT; d++) begin
			pt_q[d] <= pt_q[d-1];
			ax_q[d] <= ax_q[d-1];
		end
	end

	// ---------------- valid chain after the CORDIC ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= cs_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ---------------- stage 1: t = 1 - c, axis pair products ----------------
	// uv order: xx, yy, zz, xy, xz, yz
	logic signed [CD_W-1:0]   c_s1, s_s1, t_s1;
	logic signed [UV_W-1:0]   uv_s1 [0:5];
	logic signed [AXIS_W-1:0] ax_s1 [0:2];
	logic signed [CW-1:0]     pt_s1 [0:2];

	always_ff @(posedge clk) begin
		c_s1     <= cos_v;
		s_s1     <= sin_v;
		t_s1     <= ONE_Q30 - cos_v;
		uv_s1[0] <= ax_q[LAT-1][0] * ax_q[LAT-1][0];
		uv_s1[1] <= ax_q[LAT-1][1] * ax_q[LAT-1][1];
		uv_s1[2] <= ax_q[LAT-1][2] * ax_q[LAT-1][2];
		uv_s1[3] <= ax_q[LAT-1][0] * ax_q[LAT-1][1];
		uv_s1[4] <= ax_q[LAT-1][0] * ax_q[LAT-1][2];
		uv_s1[5] <= ax_q[LAT-1][1] * ax_q[LAT-1][2];
		ax_s1    <= ax_q[LAT-1];
		pt_s1    <= pt_q[LAT-1];
	end

	// ---------------- stage 2: outer and cross terms, rounded ----------------
	logic signed [MAT_W-1:0] c_s2;
	logic signed [MAT_W-1:0] out_s2 [0:5];
	logic signed [MAT_W-1:0] crs_s2 [0:2];
	logic signed [CW-1:0]    pt_s2  [0:2];
	logic signed [OP_W-1:0]  op_w   [0:5];
	logic signed [CP_W-1:0]  cp_w   [0:2];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			op_w[k] = (OP_W'(t_s1) * OP_W'(uv_s1[k]) + (OP_W'(1) <<< 27)) >>> 28;
		end
		for (int k = 0; k < 3; k++) begin
			cp_w[k] = (CP_W'(s_s1) * CP_W'(ax_s1[k]) + (CP_W'(1) <<< 13)) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		c_s2 <= MAT_W'(c_s1);
		for (int k = 0; k < 6; k++) out_s2[k] <= op_w[k][MAT_W-1:0];
		for (int k = 0; k < 3; k++) crs_s2[k] <= cp_w[k][MAT_W-1:0];
		pt_s2 <= pt_s1;
	end

	// ---------------- stage 3: Rodrigues matrix ----------------
	logic signed [MAT_W-1:0] m_s3  [0:8];
	logic signed [CW-1:0]    pt_s3 [0:2];

	always_ff @(posedge clk) begin
		m_s3[0] <= c_s2 + out_s2[0];
		m_s3[1] <= out_s2[3] - crs_s2[2];
		m_s3[2] <= out_s2[4] + crs_s2[1];
		m_s3[3] <= out_s2[3] + crs_s2[2];
		m_s3[4] <= c_s2 + out_s2[1];
		m_s3[5] <= out_s2[5] - crs_s2[0];
		m_s3[6] <= out_s2[4] - crs_s2[1];
		m_s3[7] <= out_s2[5] + crs_s2[0];
		m_s3[8] <= c_s2 + out_s2[2];
		pt_s3   <= pt_s2;
	end

	// ---------------- stage 4: entry times high and low point halves --------
	logic signed [HP_W-1:0] hp_s4 [0:8];
	logic signed [LP_W-1:0] lp_s4 [0:8];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				hp_s4[3*r+k] <= HP_W'(m_s3[3*r+k])
					* HP_W'($signed(pt_s3[k][CW-1:SPLIT]));
				lp_s4[3*r+k] <= LP_W'(m_s3[3*r+k])
					* LP_W'($signed({1'b0, pt_s3[k][SPLIT-1:0]}));
			end
		end
	end

	// ---------------- stage 5: row sums ----------------
	logic signed [HS_W-1:0] hs_s5 [0:2];
	logic signed [LS_W-1:0] ls_s5 [0:2];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			hs_s5[r] <= HS_W'(hp_s4[3*r]) + HS_W'(hp_s4[3*r+1]) + HS_W'(hp_s4[3*r+2]);
			ls_s5[r] <= LS_W'(lp_s4[3*r]) + LS_W'(lp_s4[3*r+1]) + LS_W'(lp_s4[3*r+2]);
		end
	end

	// ---------------- stage 6: recombine and round Q.46 to Q16.16 -----------
	logic signed [RES_W-1:0] res_s6 [0:2];
	logic signed [TOT_W-1:0] tot_w  [0:2];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tot_w[r] = ((TOT_W'(hs_s5[r]) <<< SPLIT) + TOT_W'(ls_s5[r])
				+ (TOT_W'(1) <<< 29)) >>> 30;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) res_s6[r] <= tot_w[r][RES_W-1:0];
	end

	// ---------------- stage 7: saturate and drive the result ----------------
	logic signed [CW-1:0] sat_w [0:2];
	logic [2:0]           ovf_w;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			// Overflow when the bits above the sign are not a copy of it.
			ovf_w[r] = (res_s6[r][RES_W-1:CW-1] != {(RES_W-CW+1){1'b0}})
				&& (res_s6[r][RES_W-1:CW-1] != {(RES_W-CW+1){1'b1}});
			if (ovf_w[r]) begin
				sat_w[r] = res_s6[r][RES_W-1] ? {1'b1, {(CW-1){1'b0}}}
					: {1'b0, {(CW-1){1'b1}}};
			end else begin
				sat_w[r] = res_s6[r][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rotated_x <= sat_w[0];
		rotated_y <= sat_w[1];
		rotated_z <= sat_w[2];
		clipped   <= |ovf_w;
	end

	assign done = v_s7;

	// ---------------- assertions ----------------
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a stall-free pipeline");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(CORDIC_STEPS + 9) done)
		else $error("started beat did not complete at the expected cycle");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s6) && $past(cs_valid, 7))
		else $error("result strobe without a beat in flight");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the axis-angle point rotation pipeline.
// ----------------------------------------------------------------------------
// A bit-exact predictor forms the rotation matrix from a CORDIC sine and
// cosine, then applies it to the point. The expected results are queued at the
// moment each beat is taken. Every done beat is checked against the oldest
// entry in the queue. The stimulus starts with a short directed set covering
// the extreme values. After that come random beats: mostly unit axes with
// random points and angles, then raw, arbitrary axis words. The sender runs
// in bursts of random length with gaps between them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import aap_pkg::*;
();

	localparam int CW        = 32;
	localparam int STEPS     = 16;
	localparam int LATENCY   = STEPS + 9;
	localparam int IDLE_MAX  = 4000;
	localparam int N_UNIT    = 1500;
	localparam int N_RAW     = 430;

	// Arctangent of 2^-i as a 32-bit binary angle (a full turn is 2^32).
	localparam longint ATAN_Q32 [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 clip;
	} rotated_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic signed [CW-1:0]        point_x, point_y, point_z;
	logic signed [AXIS_W-1:0]    axis_x, axis_y, axis_z;
	logic signed [ANGLE_W-1:0]   turn_angle;
	logic                        done;
	logic signed [CW-1:0]        rotated_x, rotated_y, rotated_z;
	logic                        clipped;

	rotated_t    pending_rotations[$];
	int unsigned mismatches;
	int unsigned beats_sent;
	int unsigned beats_checked;
	int unsigned clip_seen;
	int unsigned idle_cycles;

	axis_angle_point_rotation #(
		.COORD_WIDTH (CW),
		.CORDIC_STEPS(STEPS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.axis_z    (axis_z),
		.turn_angle(turn_angle),
		.done      (done),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.rotated_z (rotated_z),
		.clipped   (clipped)
	);

	always #5 clk = ~clk;

	// Outer-product term (t*u*v) rounded from Q.58 to Q.30.
	function automatic longint outer_term(input longint t, input longint u, input longint v);
		return (t * (u * v) + (64'sd1 <<< 27)) >>> 28;
	endfunction

	// Cross-product term s*w rounded from Q.44 to Q.30.
	function automatic longint cross_term(input longint s, input longint w);
		return (s * w + (64'sd1 <<< 13)) >>> 14;
	endfunction

	function automatic rotated_t predict_rotation(
		input logic signed [CW-1:0]      px, py, pz,
		input logic signed [AXIS_W-1:0]  ux, uy, uz,
		input logic signed [ANGLE_W-1:0] ang
	);
		logic [31:0]          bang;
		logic                 fold;
		longint               cx, sy, phase, dx, dy, c, s, t, ax, ay, az;
		longint               mat[9];
		longint               pt[3];
		logic signed [95:0]   acc, ent, crd;
		logic signed [95:0]   lim_hi, lim_lo;
		logic signed [CW-1:0] res[3];
		rotated_t             r;

		ax = ux; ay = uy; az = uz;
		pt[0] = px; pt[1] = py; pt[2] = pz;
		lim_hi = 96'sd2147483647;
		lim_lo = -96'sd2147483648;

		// Fold the angle into the right half plane and undo it on the outputs.
		bang = {ang, 16'h0000};
		fold = bang[31] ^ bang[30];
		if (fold)
			bang[31] = ~bang[31];
		phase = longint'(signed'(bang));

		cx = GAIN_Q30;
		sy = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = sy >>> i;
			dy = cx >>> i;
			if (phase >= 0) begin
				cx -= dx; sy += dy; phase -= ATAN_Q32[i];
			end else begin
				cx += dx; sy -= dy; phase += ATAN_Q32[i];
			end
		end
		c = fold ? -cx : cx;
		s = fold ? -sy : sy;
		t = (64'sd1 <<< 30) - c;

		mat[0] = c + outer_term(t, ax, ax);
		mat[1] = outer_term(t, ax, ay) - cross_term(s, az);
		mat[2] = outer_term(t, ax, az) + cross_term(s, ay);
		mat[3] = outer_term(t, ax, ay) + cross_term(s, az);
		mat[4] = c + outer_term(t, ay, ay);
		mat[5] = outer_term(t, ay, az) - cross_term(s, ax);
		mat[6] = outer_term(t, ax, az) - cross_term(s, ay);
		mat[7] = outer_term(t, ay, az) + cross_term(s, ax);
		mat[8] = c + outer_term(t, az, az);

		r.clip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			acc = '0;
			for (int j = 0; j < 3; j++) begin
				ent = mat[3*k+j];
				crd = pt[j];
				acc += ent * crd;
			end
			acc = (acc + (96'sd1 <<< 29)) >>> 30;
			if (acc > lim_hi) begin
				acc = lim_hi; r.clip = 1'b1;
			end
			if (acc < lim_lo) begin
				acc = lim_lo; r.clip = 1'b1;
			end
			res[k] = acc[CW-1:0];
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		return r;
	endfunction

	// Queue the expected rotation for every beat that the block takes.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			pending_rotations.push_back(predict_rotation(point_x, point_y, point_z,
				axis_x, axis_y, axis_z, turn_angle));
			beats_sent++;
		end
	end

	// Check each result beat against the oldest expectation.
	always @(posedge clk) begin
		rotated_t want;
		if (arst_n && done) begin
			if (pending_rotations.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result beat with nothing expected: %0d %0d %0d clip=%0b",
						rotated_x, rotated_y, rotated_z, clipped);
			end else begin
				want = pending_rotations.pop_front();
				beats_checked++;
				if (want.clip)
					clip_seen++;
				if (rotated_x !== want.x || rotated_y !== want.y ||
						rotated_z !== want.z || clipped !== want.clip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: beat %0d expected %0d %0d %0d clip=%0b, got %0d %0d %0d clip=%0b",
							beats_checked, want.x, want.y, want.z, want.clip,
							rotated_x, rotated_y, rotated_z, clipped);
				end
			end
		end
	end

	// Watchdog: give up when neither side has moved for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("ERROR: no beat moved for %0d cycles", IDLE_MAX);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one beat and hold it until the block takes it. Start stays
	// high afterward, so the caller drops it when a burst ends.
	task automatic send_point(
		input logic signed [CW-1:0]      px, py, pz,
		input logic signed [AXIS_W-1:0]  ux, uy, uz,
		input logic signed [ANGLE_W-1:0] ang
	);
		logic taken;
		point_x    <= px;
		point_y    <= py;
		point_z    <= pz;
		axis_x     <= ux;
		axis_y     <= uy;
		axis_z     <= uz;
		turn_angle <= ang;
		start      <= 1'b1;
		do begin
			@(posedge clk);
			taken = !busy;
		end while (!taken);
	endtask

	// End a burst with probability about one in four, then idle for a while.
	task automatic maybe_pause();
		int gap;
		if ($urandom_range(3) == 0) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		// Mostly modest coordinates, sometimes the full range.
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
	endfunction

	task automatic test_directed();
		logic signed [CW-1:0] big, low;
		big = 32'sh7FFF_FFFF;
		low = 32'sh8000_0000;
		// Zero angle and zero point.
		send_point(0, 0, 0, 16384, 0, 0, 0);
		send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 16384, 0);
		// Quarter turns about each cardinal axis, both signs.
		send_point(32'sh0001_0000, 0, 0, 0, 0, 16384, 16384);
		send_point(0, 32'sh0001_0000, 0, 16384, 0, 0, -16384);
		send_point(0, 0, 32'sh0001_0000, 0, 16384, 0, 16384);
		send_point(32'sh0001_0000, 0, 0, 0, 0, -16384, 16384);
		// Half turn given as minus pi, and the largest positive angle.
		send_point(32'sh0005_0000, -32'sh0003_0000, 32'sh0001_0000, 0, 0, 16384, -32768);
		send_point(32'sh0005_0000, -32'sh0003_0000, 32'sh0001_0000, 0, 16384, 0, 32767);
		send_point(32'sh0001_0000, 32'sh0001_0000, 0, -16384, 0, 0, 1);
		send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0, -16384, 0, -1);
		// Axes that are not unit length, including the most negative word.
		send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
			-32768, -32768, -32768, 8192);
		send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
			32767, 32767, 32767, -8192);
		send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 12345);
		// Extreme coordinates: an eighth turn pushes these beyond the range.
		send_point(big, big, big, 0, 0, 16384, 8192);
		send_point(low, low, low, 0, 0, 16384, 8192);
		send_point(big, low, big, 16384, 0, 0, -8192);
		send_point(low, big, low, 0, 16384, 0, -32768);
		send_point(big, big, low, 11585, 11585, 0, 16384);
		send_point(-1, 1, -1, 9459, 9459, 9459, 21845);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Random unit axes, random points and angles, bursty sender.
	task automatic test_unit_axes();
		real vx, vy, vz, len;
		logic signed [AXIS_W-1:0] ux, uy, uz;
		for (int n = 0; n < N_UNIT; n++) begin
			do begin
				vx = $itor($signed($urandom_range(0, 2000))) - 1000.0;
				vy = $itor($signed($urandom_range(0, 2000))) - 1000.0;
				vz = $itor($signed($urandom_range(0, 2000))) - 1000.0;
				len = $sqrt(vx*vx + vy*vy + vz*vz);
			end while (len < 1.0);
			ux = AXIS_W'($rtoi(vx / len * 16384.0));
			uy = AXIS_W'($rtoi(vy / len * 16384.0));
			uz = AXIS_W'($rtoi(vz / len * 16384.0));
			send_point(rand_coord(), rand_coord(), rand_coord(), ux, uy, uz,
				ANGLE_W'($urandom));
			maybe_pause();
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Arbitrary axis words, so every axis bit toggles; longer bursts.
	task automatic test_raw_axes();
		for (int n = 0; n < N_RAW; n++) begin
			send_point(CW'($urandom), CW'($urandom), rand_coord(),
				AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
				ANGLE_W'($urandom));
			if ($urandom_range(7) == 0)
				maybe_pause();
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_pipeline();
		int waited;
		waited = 0;
		while (pending_rotations.size() != 0 && waited < 100 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		axis_x      = '0;
		axis_y      = '0;
		axis_z      = '0;
		turn_angle  = '0;
		mismatches  = 0;
		beats_sent  = 0;
		beats_checked = 0;
		clip_seen   = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_unit_axes();
		test_raw_axes();
		drain_pipeline();

		if (pending_rotations.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d results never arrived", pending_rotations.size());
		end
		$display("Ran %0d beats through the rotation pipeline, checked %0d results (%0d saturated).",
			beats_sent, beats_checked, clip_seen);
		$display("Covered cardinal and random unit axes, raw axis words, and angle extremes.");
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
